// ===== rtl/pk12_pkg.sv =====
package pk12_pkg;

  localparam int unsigned HdrLen    = 32;
  localparam int unsigned StoreBase = 22;
  localparam int unsigned StoreEnd  = 30;
  localparam int unsigned MagicLen  = 6;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [1:0] ERR_TRUNCATED = 2'd0;
  localparam logic [1:0] ERR_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ERR_LOOP_MODE = 2'd2;

  localparam logic [1:0] SRC_CODE    = 2'd0;
  localparam logic [1:0] SRC_MARKERS = 2'd1;
  localparam logic [1:0] SRC_DEFAULT = 2'd2;

  localparam logic [7:0] LOOP_ON  = 8'h49;
  localparam logic [7:0] LOOP_OFF = 8'hc9;

  localparam logic [7:0] RATE_CODE_33K = 8'h01;
  localparam logic [7:0] RATE_CODE_50K = 8'h02;
  localparam logic [7:0] RATE_CODE_16K = 8'h03;

  localparam logic [7:0] MARK_MASK   = 8'hfe;
  localparam logic [7:0] MARK_A_33K  = 8'h06;
  localparam logic [7:0] MARK_R_33K  = 8'h52;
  localparam logic [7:0] MARK_A_50K  = 8'h10;
  localparam logic [7:0] MARK_R_50K  = 8'h00;
  localparam logic [7:0] MARK_A_16K  = 8'hf6;
  localparam logic [7:0] MARK_R_16K  = 8'h52;

  localparam logic [15:0] HZ_33K = 16'd33333;
  localparam logic [15:0] HZ_50K = 16'd50000;
  localparam logic [15:0] HZ_16K = 16'd16667;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [15:0]        rate_hz;
    logic [1:0]         rate_source;
    logic               looped;
    logic [16:0]        attack_len;
    logic [16:0]        repeat_len;
    logic [1:0]         error_code;
    logic               end_of_run;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

  function automatic logic [7:0] magic_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h4c;
      3'd1:    b = 8'h4d;
      3'd2:    b = 8'h38;
      3'd3:    b = 8'h39;
      3'd4:    b = 8'h35;
      3'd5:    b = 8'h33;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic res_t mk_error(logic [1:0] code);
    res_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.end_of_run = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_done();
    res_t r;
    r            = '0;
    r.kind       = KIND_DONE;
    r.end_of_run = 1'b1;
    return r;
  endfunction

  // sign-extend 12 bits, times 16
  function automatic res_t mk_sample(logic [11:0] packed12);
    res_t r;
    r        = '0;
    r.kind   = KIND_SAMPLE;
    r.sample = {packed12, 4'b0000};
    return r;
  endfunction

endpackage

// ===== rtl/pk12_byte_if.sv =====
interface pk12_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/pk12_res_if.sv =====
interface pk12_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample;
  logic [15:0]        rate_hz;
  logic [1:0]         rate_source;
  logic               looped;
  logic [16:0]        attack_len;
  logic [16:0]        repeat_len;
  logic [1:0]         error_code;
  logic               end_of_run;

  modport source (output valid, output kind, output sample, output rate_hz,
                  output rate_source, output looped, output attack_len,
                  output repeat_len, output error_code, output end_of_run,
                  input ready);
  modport sink (input valid, input kind, input sample, input rate_hz,
                input rate_source, input looped, input attack_len,
                input repeat_len, input error_code, input end_of_run,
                output ready);
endinterface

// ===== rtl/pk12_parse.sv =====
module pk12_parse
  import pk12_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output push_t      push_o,
  output res_t       res0_o,
  output res_t       res1_o
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_MIDDLE = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  localparam logic [5:0] POS_MAGIC_END = 6'(MagicLen);
  localparam logic [5:0] POS_BASE      = 6'(StoreBase);
  localparam logic [5:0] POS_STORE_END = 6'(StoreEnd);
  localparam logic [5:0] POS_LAST_HDR  = 6'(HdrLen - 1);
  localparam logic [5:0] POS_PAYLOAD   = 6'(HdrLen);

  logic [5:0]  pos_q, pos_d;
  logic        magic_q, magic_d;
  logic [7:0]  store_q [8];
  logic [7:0]  store_d [8];
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  mid_q, mid_d;
  logic [17:0] frames_q, frames_d;
  logic        skip_q, skip_d;

  logic [16:0] attack;
  logic [16:0] repeat_n;
  logic [17:0] total;
  logic [5:0]  off;
  logic [7:0]  mark_a;
  logic [7:0]  mark_r;
  logic        emit;
  logic [17:0] frames_nx;
  logic        ended;
  logic        clear;
  res_t        hdr;
  res_t        r0, r1;
  logic        v0, v1;

  assign attack   = {store_q[4][0], store_q[3], store_q[2]};
  assign repeat_n = {store_q[7][0], store_q[6], store_q[5]};
  assign total    = {1'b0, attack} + {1'b0, repeat_n};
  assign off      = pos_q - POS_BASE;
  assign mark_a   = store_q[4] & MARK_MASK;
  assign mark_r   = store_q[7] & MARK_MASK;

  always_comb begin
    hdr            = '0;
    hdr.kind       = KIND_HEADER;
    hdr.looped     = (store_q[0] == LOOP_ON);
    hdr.attack_len = attack;
    hdr.repeat_len = repeat_n;
    if (store_q[1] == RATE_CODE_33K) begin
      hdr.rate_hz = HZ_33K; hdr.rate_source = SRC_CODE;
    end else if (store_q[1] == RATE_CODE_50K) begin
      hdr.rate_hz = HZ_50K; hdr.rate_source = SRC_CODE;
    end else if (store_q[1] == RATE_CODE_16K) begin
      hdr.rate_hz = HZ_16K; hdr.rate_source = SRC_CODE;
    end else if (mark_a == MARK_A_33K && mark_r == MARK_R_33K) begin
      hdr.rate_hz = HZ_33K; hdr.rate_source = SRC_MARKERS;
    end else if (mark_a == MARK_A_50K && mark_r == MARK_R_50K) begin
      hdr.rate_hz = HZ_50K; hdr.rate_source = SRC_MARKERS;
    end else if (mark_a == MARK_A_16K && mark_r == MARK_R_16K) begin
      hdr.rate_hz = HZ_16K; hdr.rate_source = SRC_MARKERS;
    end else begin
      hdr.rate_hz = HZ_33K; hdr.rate_source = SRC_DEFAULT;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    magic_d   = magic_q;
    store_d   = store_q;
    phase_d   = phase_q;
    first_d   = first_q;
    mid_d     = mid_q;
    frames_d  = frames_q;
    skip_d    = skip_q;
    r0        = '0;
    r1        = '0;
    v0        = 1'b0;
    v1        = 1'b0;
    ended     = 1'b0;
    clear     = 1'b0;
    emit      = 1'b0;
    frames_nx = frames_q;
    if (fire_i) begin
      if (skip_q) begin
        clear = last_i;
      end else if (pos_q != POS_PAYLOAD) begin
        if (pos_q < POS_MAGIC_END && data_i != magic_byte(pos_q[2:0])) begin
          magic_d = 1'b0;
        end
        if (pos_q >= POS_BASE && pos_q < POS_STORE_END) begin
          store_d[off[2:0]] = data_i;
        end
        if (pos_q != POS_LAST_HDR) begin
          pos_d = pos_q + 6'd1;
          if (last_i) begin
            r0 = mk_error(ERR_TRUNCATED); v0 = 1'b1; ended = 1'b1;
          end
        end else if (!magic_q) begin
          r0 = mk_error(ERR_BAD_MAGIC); v0 = 1'b1; ended = 1'b1;
        end else if (store_q[0] != LOOP_ON && store_q[0] != LOOP_OFF) begin
          r0 = mk_error(ERR_LOOP_MODE); v0 = 1'b1; ended = 1'b1;
        end else begin
          r0    = hdr;
          v0    = 1'b1;
          pos_d = POS_PAYLOAD;
          if (total == '0) begin
            r1 = mk_done(); v1 = 1'b1; ended = 1'b1;
          end else if (last_i) begin
            r1 = mk_error(ERR_TRUNCATED); v1 = 1'b1; ended = 1'b1;
          end
        end
      end else begin
        case (phase_q)
          PH_FIRST: begin
            first_d = data_i;
            phase_d = PH_MIDDLE;
          end
          PH_MIDDLE: begin
            mid_d    = data_i;
            r0       = mk_sample({first_q, data_i[7:4]});
            v0       = 1'b1;
            frames_d = frames_q + 18'd1;
            phase_d  = PH_SECOND;
          end
          default: begin
            emit      = (frames_q < total);
            frames_nx = frames_q + {17'd0, emit};
            frames_d  = frames_nx;
            phase_d   = PH_FIRST;
            if (emit) begin
              r0 = mk_sample({data_i, mid_q[3:0]});
              v0 = 1'b1;
            end
            if (frames_nx >= total) begin
              ended = 1'b1;
              if (emit) begin
                r1 = mk_done(); v1 = 1'b1;
              end else begin
                r0 = mk_done(); v0 = 1'b1;
              end
            end
          end
        endcase
        if (!ended && last_i) begin
          ended = 1'b1;
          if (v0) begin
            r1 = mk_error(ERR_TRUNCATED); v1 = 1'b1;
          end else begin
            r0 = mk_error(ERR_TRUNCATED); v0 = 1'b1;
          end
        end
      end
      if (ended) begin
        if (last_i) clear = 1'b1;
        else        skip_d = 1'b1;
      end
      if (clear) begin
        pos_d    = '0;
        magic_d  = 1'b1;
        store_d  = '{default: 8'h00};
        phase_d  = PH_FIRST;
        first_d  = '0;
        mid_d    = '0;
        frames_d = '0;
        skip_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      magic_q  <= 1'b1;
      store_q  <= '{default: 8'h00};
      phase_q  <= PH_FIRST;
      first_q  <= '0;
      mid_q    <= '0;
      frames_q <= '0;
      skip_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      magic_q  <= magic_d;
      store_q  <= store_d;
      phase_q  <= phase_d;
      first_q  <= first_d;
      mid_q    <= mid_d;
      frames_q <= frames_d;
      skip_q   <= skip_d;
    end
  end

  assign push_o.v0 = v0;
  assign push_o.v1 = v1;
  assign res0_o    = r0;
  assign res1_o    = r1;

endmodule

// ===== rtl/pk12_out_fifo.sv =====
module pk12_out_fifo
  import pk12_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  res_t  res0_i,
  input  res_t  res1_i,
  input  logic  pop_i,
  output logic  room2_o,
  output logic  valid_o,
  output res_t  res_o
);

  res_t       mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] n_push;

  assign valid_o = (cnt_q != 3'd0);
  assign room2_o = (cnt_q <= 3'd2);
  assign res_o   = mem_q[rd_q];
  assign pop     = pop_i && valid_o;
  assign n_push  = {1'b0, push_i.v0} + {1'b0, push_i.v1};

  always_comb begin
    wr_d  = wr_q + n_push;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, n_push} - {2'b00, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wr_q] <= res0_i;
    if (push_i.v1) mem_q[wr_q + 2'd1] <= res1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/packed_12bit_sample_file_decoder.sv =====
// Channel   Dir   Word
// byte_i    in    data_byte, last_byte
// res_o     out   kind, sample, rate_hz, rate_source, looped,
//                 attack_len, repeat_len, error_code, end_of_run
//
// One byte per cycle while byte_i.ready is high; each byte is decoded in the
// cycle it is taken and its zero, one or two result words land in a
// four-entry output queue. A result word is registered in the queue before
// it is offered; a byte that yields two words writes both in the same cycle.
// byte_i.ready drops while the queue holds three or more words.
// Reset (async, active low) empties the queue and returns the header parser
// to the start of a file.
module packed_12bit_sample_file_decoder
  import pk12_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pk12_byte_if.sink   byte_i,
  pk12_res_if.source  res_o
);

  logic  fire;
  logic  room2;
  logic  q_valid;
  push_t push;
  res_t  res0;
  res_t  res1;
  res_t  head;

  assign byte_i.ready = room2;
  assign fire         = byte_i.valid && room2;

  pk12_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .data_i (byte_i.data_byte),
    .last_i (byte_i.last_byte),
    .push_o (push),
    .res0_o (res0),
    .res1_o (res1)
  );

  pk12_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res0_i  (res0),
    .res1_i  (res1),
    .pop_i   (res_o.ready),
    .room2_o (room2),
    .valid_o (q_valid),
    .res_o   (head)
  );

  assign res_o.valid       = q_valid;
  assign res_o.kind        = head.kind;
  assign res_o.sample      = head.sample;
  assign res_o.rate_hz     = head.rate_hz;
  assign res_o.rate_source = head.rate_source;
  assign res_o.looped      = head.looped;
  assign res_o.attack_len  = head.attack_len;
  assign res_o.repeat_len  = head.repeat_len;
  assign res_o.error_code  = head.error_code;
  assign res_o.end_of_run  = head.end_of_run;

endmodule

// ===== sim/tb_packed_12bit_sample_file_decoder.sv =====
module tb_packed_12bit_sample_file_decoder;
  import pk12_pkg::*;

  localparam int unsigned RandBytes   = 430;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned IdlePct     = 29;
  localparam int unsigned CalmFrom    = 300;
  localparam int unsigned CalmTo      = 450;

  localparam logic [47:0] FileTag = 48'h4c4d38393533;

  // offsets into the stored header bytes 22..29
  localparam int unsigned HsLoop   = 0;
  localparam int unsigned HsCode   = 1;
  localparam int unsigned HsAttack = 2;
  localparam int unsigned HsRepeat = 5;

  localparam logic [7:0] RATE_CODE_NONE = 8'h00;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } file_word_t;

  logic clk_i;
  logic rst_ni;
  logic calm;

  pk12_byte_if byte_if();
  pk12_res_if  res_if();

  packed_12bit_sample_file_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if.sink),
    .res_o  (res_if.source)
  );

  file_word_t  send_q[$];
  res_t        due_results[$];
  logic [7:0]  file_bytes[$];
  file_word_t  next_word;
  int unsigned total_items;
  int unsigned bytes_taken;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // decoder state as tracked by the testbench
  int unsigned hdr_pos;
  logic        magic_ok;
  logic [7:0]  hdr_store [8];
  logic [1:0]  grp_phase;
  logic [7:0]  held_hi;
  logic [7:0]  held_mid;
  logic [17:0] frames_out;
  logic        skipping;

  assign calm = (bytes_taken >= CalmFrom) && (bytes_taken < CalmTo);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic expect_word(res_t r);
    due_results.insert(due_results.size(), r);
  endtask

  task automatic add_byte(logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  task automatic clear_decoder();
    hdr_pos    = 0;
    magic_ok   = 1'b1;
    for (int i = 0; i < 8; i++) hdr_store[i] = '0;
    grp_phase  = '0;
    held_hi    = '0;
    held_mid   = '0;
    frames_out = '0;
    skipping   = 1'b0;
  endtask

  function automatic logic [16:0] part_len(int unsigned at);
    return {hdr_store[at+2][0], hdr_store[at+1], hdr_store[at]};
  endfunction

  function automatic res_t fault_word(logic [1:0] code);
    res_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic res_t sample_word(logic [11:0] p);
    res_t r;
    r        = '0;
    r.kind   = KIND_SAMPLE;
    r.sample = $signed({{4{p[11]}}, p}) * 16;
    return r;
  endfunction

  task automatic close_file(res_t r, logic is_last);
    r.end_of_run = 1'b1;
    expect_word(r);
    if (is_last) clear_decoder();
    else skipping = 1'b1;
  endtask

  task automatic decode_file_byte(logic [7:0] b, logic is_last);
    res_t        r;
    logic [7:0]  code;
    logic [7:0]  am;
    logic [7:0]  rm;
    logic [17:0] total;
    logic        ended;
    if (skipping) begin
      if (is_last) clear_decoder();
      return;
    end
    if (hdr_pos < HdrLen) begin
      if (hdr_pos < MagicLen && b != FileTag[47-8*hdr_pos -: 8]) magic_ok = 1'b0;
      if (hdr_pos >= StoreBase && hdr_pos < StoreEnd) hdr_store[hdr_pos-StoreBase] = b;
      if (hdr_pos < HdrLen - 1) begin
        hdr_pos++;
        if (is_last) close_file(fault_word(ERR_TRUNCATED), is_last);
      end else if (!magic_ok) begin
        close_file(fault_word(ERR_BAD_MAGIC), is_last);
      end else if (hdr_store[HsLoop] != LOOP_ON && hdr_store[HsLoop] != LOOP_OFF) begin
        close_file(fault_word(ERR_LOOP_MODE), is_last);
      end else begin
        r      = '0;
        r.kind = KIND_HEADER;
        code   = hdr_store[HsCode];
        am     = hdr_store[HsAttack+2] & MARK_MASK;
        rm     = hdr_store[HsRepeat+2] & MARK_MASK;
        if (code == RATE_CODE_33K) begin
          r.rate_hz = HZ_33K; r.rate_source = SRC_CODE;
        end else if (code == RATE_CODE_50K) begin
          r.rate_hz = HZ_50K; r.rate_source = SRC_CODE;
        end else if (code == RATE_CODE_16K) begin
          r.rate_hz = HZ_16K; r.rate_source = SRC_CODE;
        end else if (am == MARK_A_33K && rm == MARK_R_33K) begin
          r.rate_hz = HZ_33K; r.rate_source = SRC_MARKERS;
        end else if (am == MARK_A_50K && rm == MARK_R_50K) begin
          r.rate_hz = HZ_50K; r.rate_source = SRC_MARKERS;
        end else if (am == MARK_A_16K && rm == MARK_R_16K) begin
          r.rate_hz = HZ_16K; r.rate_source = SRC_MARKERS;
        end else begin
          r.rate_hz = HZ_33K; r.rate_source = SRC_DEFAULT;
        end
        r.looped     = hdr_store[HsLoop] == LOOP_ON;
        r.attack_len = part_len(HsAttack);
        r.repeat_len = part_len(HsRepeat);
        expect_word(r);
        hdr_pos = HdrLen;
        if (r.attack_len + r.repeat_len == 0) begin
          r      = '0;
          r.kind = KIND_DONE;
          close_file(r, is_last);
        end else if (is_last) begin
          close_file(fault_word(ERR_TRUNCATED), is_last);
        end
      end
    end else begin
      total = part_len(HsAttack) + part_len(HsRepeat);
      ended = 1'b0;
      case (grp_phase)
        2'd0: begin
          held_hi   = b;
          grp_phase = 2'd1;
        end
        2'd1: begin
          held_mid = b;
          expect_word(sample_word({held_hi, b[7:4]}));
          frames_out++;
          grp_phase = 2'd2;
        end
        default: begin
          if (frames_out < total) begin
            expect_word(sample_word({b, held_mid[3:0]}));
            frames_out++;
          end
          grp_phase = 2'd0;
          if (frames_out >= total) begin
            r      = '0;
            r.kind = KIND_DONE;
            close_file(r, is_last);
            ended = 1'b1;
          end
        end
      endcase
      if (!ended && is_last) close_file(fault_word(ERR_TRUNCATED), is_last);
    end
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got = {res_if.kind, res_if.sample, res_if.rate_hz, res_if.rate_source, res_if.looped,
           res_if.attack_len, res_if.repeat_len, res_if.error_code, res_if.end_of_run};
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result word, kind %0d", got.kind));
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.sample !== want.sample)
      report_mismatch($sformatf("sample %0d, want %0d", got.sample, want.sample));
    if (got.rate_hz !== want.rate_hz)
      report_mismatch($sformatf("rate_hz %0d, want %0d", got.rate_hz, want.rate_hz));
    if (got.rate_source !== want.rate_source)
      report_mismatch($sformatf("rate_source %0d, want %0d", got.rate_source,
                                want.rate_source));
    if (got.looped !== want.looped)
      report_mismatch($sformatf("looped %0d, want %0d", got.looped, want.looped));
    if (got.attack_len !== want.attack_len)
      report_mismatch($sformatf("attack_len %0d, want %0d", got.attack_len,
                                want.attack_len));
    if (got.repeat_len !== want.repeat_len)
      report_mismatch($sformatf("repeat_len %0d, want %0d", got.repeat_len,
                                want.repeat_len));
    if (got.error_code !== want.error_code)
      report_mismatch($sformatf("error_code %0d, want %0d", got.error_code,
                                want.error_code));
    if (got.end_of_run !== want.end_of_run)
      report_mismatch($sformatf("end_of_run %0d, want %0d", got.end_of_run,
                                want.end_of_run));
  endtask

  task automatic start_file(logic [7:0] loop_mode, logic [7:0] code, logic [16:0] atk,
                            logic [16:0] rep, logic [7:0] a_mark, logic [7:0] r_mark);
    file_bytes.delete();
    for (int i = 0; i < HdrLen; i++)
      add_byte(i < MagicLen ? FileTag[47-8*i -: 8] : 8'($urandom));
    file_bytes[StoreBase+HsLoop]     = loop_mode;
    file_bytes[StoreBase+HsCode]     = code;
    file_bytes[StoreBase+HsAttack]   = atk[7:0];
    file_bytes[StoreBase+HsAttack+1] = atk[15:8];
    file_bytes[StoreBase+HsAttack+2] = {a_mark[7:1], atk[16]};
    file_bytes[StoreBase+HsRepeat]   = rep[7:0];
    file_bytes[StoreBase+HsRepeat+1] = rep[15:8];
    file_bytes[StoreBase+HsRepeat+2] = {r_mark[7:1], rep[16]};
  endtask

  task automatic add_payload(int unsigned n);
    for (int unsigned i = 0; i < n; i++) add_byte(8'($urandom));
  endtask

  task automatic send_file(int unsigned keep);
    for (int unsigned i = 0; i < keep; i++) begin
      send_q.insert(send_q.size(), {file_bytes[i], i == keep - 1});
    end
    total_items += keep;
  endtask

  task automatic random_file();
    int unsigned pick;
    int unsigned need;
    int unsigned pay;
    int unsigned keep;
    logic [16:0] atk;
    logic [16:0] rep;
    logic [7:0]  loop_mode;
    logic [7:0]  code;
    logic [7:0]  a_mark;
    logic [7:0]  r_mark;
    pick      = $urandom_range(99);
    loop_mode = $urandom_range(1) ? LOOP_ON : LOOP_OFF;
    if (pick < 6) loop_mode = 8'($urandom);
    case ($urandom_range(5))
      0:       code = RATE_CODE_33K;
      1:       code = RATE_CODE_50K;
      2:       code = RATE_CODE_16K;
      3:       code = 8'($urandom);
      default: code = RATE_CODE_NONE;
    endcase
    case ($urandom_range(4))
      0:       {a_mark, r_mark} = {MARK_A_33K, MARK_R_33K};
      1:       {a_mark, r_mark} = {MARK_A_50K, MARK_R_50K};
      2:       {a_mark, r_mark} = {MARK_A_16K, MARK_R_16K};
      default: {a_mark, r_mark} = 16'($urandom);
    endcase
    atk = $urandom_range(6);
    rep = $urandom_range(6);
    if ($urandom_range(19) == 0) atk = 17'($urandom);
    if ($urandom_range(19) == 0) rep = 17'($urandom);
    need = 3 * ((atk + rep + 1) / 2);
    start_file(loop_mode, code, atk, rep, a_mark, r_mark);
    if (pick >= 6 && pick < 10)
      file_bytes[$urandom_range(MagicLen-1)] ^= 8'(1 << $urandom_range(7));
    // huge frame counts get a short payload
    pay = need > 60 ? $urandom_range(40, 3) : need;
    add_payload(pay);
    if ($urandom_range(3) == 0) add_payload($urandom_range(4, 1));
    keep = file_bytes.size();
    if (pick >= 90) keep = $urandom_range(keep, 1);
    send_file(keep);
  endtask

  // byte source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid     <= 1'b0;
      byte_if.data_byte <= '0;
      byte_if.last_byte <= 1'b0;
    end else if (!byte_if.valid || byte_if.ready) begin
      if (send_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        next_word = send_q.pop_front();
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= next_word.value;
        byte_if.last_byte <= next_word.is_last;
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        decode_file_byte(byte_if.data_byte, byte_if.last_byte);
        bytes_taken++;
      end
      if (res_if.valid && res_if.ready) check_result();
      if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int unsigned directed_items;
    rst_ni            = 1'b0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    res_if.ready      = 1'b0;
    total_items       = 0;
    bytes_taken       = 0;
    mismatches        = 0;
    quiet_cycles      = 0;
    clear_decoder();

    // odd frame count, sample extremes, trailing bytes after done
    start_file(LOOP_ON, RATE_CODE_33K, 17'd2, 17'd1, '0, '0);
    add_byte(8'h80); add_byte(8'h07); add_byte(8'hff);
    add_byte(8'h7f); add_byte(8'hf0); add_byte(8'h00);
    add_payload(3);
    send_file(file_bytes.size());
    // empty payload, done on the final byte
    start_file(LOOP_OFF, RATE_CODE_50K, '0, '0, '0, '0);
    send_file(HdrLen);
    // exact payload, done with the last sample
    start_file(LOOP_ON, RATE_CODE_16K, 17'd3, 17'd1, '0, '0);
    add_byte(8'hff); add_byte(8'hff); add_byte(8'hff);
    add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
    send_file(file_bytes.size());
    // largest counts, marker rate, short payload
    start_file(LOOP_OFF, RATE_CODE_NONE, 17'h1ffff, 17'h1ffff, MARK_A_33K, MARK_R_33K);
    add_payload(5);
    send_file(file_bytes.size());
    start_file(LOOP_ON, 8'($urandom_range(255, 4)), 17'd1, 17'd1, MARK_A_50K, MARK_R_50K);
    add_payload(3);
    send_file(file_bytes.size());
    start_file(LOOP_OFF, RATE_CODE_NONE, 17'd0, 17'd5, MARK_A_16K, MARK_R_16K);
    add_payload(11);
    send_file(file_bytes.size());
    // unknown markers, file ends right at the header
    start_file(LOOP_ON, RATE_CODE_NONE, 17'd1, 17'd0, 8'h44, MARK_R_33K);
    send_file(HdrLen);
    // short headers
    start_file(LOOP_ON, RATE_CODE_33K, 17'd1, 17'd1, '0, '0);
    send_file(10);
    send_file(1);
    // bad magic with trailing bytes
    start_file(LOOP_ON, RATE_CODE_33K, 17'd1, 17'd1, '0, '0);
    file_bytes[3] ^= 8'h01;
    add_payload(3);
    send_file(file_bytes.size());
    // unknown loop mode on the final byte
    start_file(8'h48, RATE_CODE_33K, 17'd1, 17'd1, '0, '0);
    send_file(HdrLen);
    // empty payload with trailing bytes
    start_file(LOOP_ON, RATE_CODE_50K, '0, '0, '0, '0);
    add_payload(2);
    send_file(file_bytes.size());

    directed_items = total_items;
    while (total_items < directed_items + RandBytes) random_file();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken != total_items || due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", due_results.size()));
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
